@@ src/sipq_pkg.sv @@
// Package: defaults, field widths and codes for the sorted-insert priority queue.
`timescale 1ns / 1ps
package sipq_pkg;
    localparam int CAPACITY_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 8;

    localparam int PRIO_W    = 16;
    localparam int PAYLOAD_W = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
endpackage

@@ src/sipq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sipq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/sorted_insert_priority_queue.sv @@
// Top level: bounded priority queue kept sorted in a RAM, one compare unit.
//
//  channel  | dir | tdata (low bit up)                       | tuser
//  s_axis   | in  | prio[15:0], payload[23:16]               | op
//  m_axis   | out | prio[15:0], payload[23:16], count[28:24] | status
//
// One item at a time; ready only when idle.
// A rejected item goes straight to the output register; a dequeue reads the head entry, then
// presents it; an enqueue walks from the tail, reading and comparing one stored entry at a
// time and moving it up while its priority is higher, then writes the new item; the pace is
// set by the one-read-port RAM (registered read) and the single priority comparator.
// Entries live in a ring addressed from a head pointer. Reset clears the head pointer and count.
// A stalled result holds in the output register until taken.
`timescale 1ns / 1ps
module sorted_insert_priority_queue #(
    parameter int CAPACITY     = sipq_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = sipq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // prio[15:0], payload[23:16]
    input  logic        i_s_axis_tuser,   // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // prio[15:0], payload[23:16], count[28:24], zero pad
    output logic [1:0]  o_m_axis_tuser    // status
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = sipq_pkg::PRIO_W;
    localparam int EW = PW + PAYLOAD_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CMP, S_PUT, S_DEQ, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [PW-1:0] r_prio, n_prio;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic [PW-1:0] r_out_prio, n_out_prio;
    logic [PAYLOAD_BITS-1:0] r_out_pay, n_out_pay;
    logic [sipq_pkg::STATUS_W-1:0] r_out_st, n_out_st;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [PW-1:0] rd_prio;
    logic          accept;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    sipq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_prio = rdata[EW-1 -: PW];
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign raddr   = (r_state == S_RD) ? phys(r_head, r_idx - AW'(1)) : r_head;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_prio     = r_prio;
        n_pay      = r_pay;
        n_out_prio = r_out_prio;
        n_out_pay  = r_out_pay;
        n_out_st   = r_out_st;
        we         = 1'b0;
        waddr      = phys(r_head, r_idx);
        wdata      = {r_prio, r_pay};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_prio     = i_s_axis_tdata[PW-1:0];
                    n_pay      = PAYLOAD_BITS'(i_s_axis_tdata[23:16]);
                    n_out_prio = '0;
                    n_out_pay  = '0;
                    n_out_st   = sipq_pkg::ST_DONE;
                    n_idx      = AW'(r_count);
                    if (i_s_axis_tuser == sipq_pkg::OP_ENQ) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_out_st = sipq_pkg::ST_FULL;
                            n_state  = S_OUT;
                        end else if (r_count == '0) begin
                            n_state = S_PUT;
                        end else begin
                            n_state = S_RD;
                        end
                    end else if (r_count == '0) begin
                        n_out_st = sipq_pkg::ST_EMPTY;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_DEQ;
                    end
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (rd_prio > r_prio) begin
                    we    = 1'b1;
                    wdata = rdata;
                    n_idx = r_idx - AW'(1);
                    n_state = (r_idx == AW'(1)) ? S_PUT : S_RD;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                we      = 1'b1;
                n_count = r_count + CW'(1);
                n_state = S_OUT;
            end
            S_DEQ: begin
                n_out_prio = rd_prio;
                n_out_pay  = rdata[PAYLOAD_BITS-1:0];
                n_head     = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
                n_count    = r_count - CW'(1);
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
        r_idx      <= n_idx;
        r_prio     <= n_prio;
        r_pay      <= n_pay;
        r_out_prio <= n_out_prio;
        r_out_pay  <= n_out_pay;
        r_out_st   <= n_out_st;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {3'b000, sipq_pkg::COUNT_W'(r_count),
                              sipq_pkg::PAYLOAD_W'(r_out_pay), r_out_prio};
    assign o_m_axis_tuser  = r_out_st;
endmodule

@@ src/sipq_checker.sv @@
// Port-level checker for the sorted-insert priority queue, bound to the top level.
`timescale 1ns / 1ps
module sipq_checker #(
    parameter int CAPACITY = sipq_pkg::CAPACITY_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready right after an accepted item");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == sipq_pkg::ST_FULL) |->
        (o_m_axis_tdata[28:24] == sipq_pkg::COUNT_W'(CAPACITY) && o_m_axis_tdata[23:0] == '0))
        else $error("full rejection with wrong count or data");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == sipq_pkg::ST_EMPTY) |->
        (o_m_axis_tdata == '0))
        else $error("empty rejection with nonzero count or data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");
endmodule

bind sorted_insert_priority_queue sipq_checker #(.CAPACITY(CAPACITY)) u_sipq_checker (.*);
